>>> hw/rtl/hsra_pkg.sv
// shared types, constants and arithmetic helpers of the hash row accumulator
package hsra_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int CNT_W       = 7;
  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;
  localparam int CFG_W       = 16;

  localparam logic [1:0] REG_TABLE_SIZE_LOG2 = 2'd0;
  localparam logic [1:0] REG_HASH_MULTIPLIER = 2'd1;
  localparam logic [1:0] REG_SORT_OUTPUT     = 2'd2;

  localparam logic KIND_ACCUM = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // table access request from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              set_used;
    logic              clear_all;
  } tbl_req_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MUL    = 10'b0000000010,
    S_SAT    = 10'b0000000100,
    S_PROBE  = 10'b0000001000,
    S_CMP    = 10'b0000010000,
    S_EMPTY  = 10'b0000100000,
    S_USCAN  = 10'b0001000000,
    S_UFETCH = 10'b0010000000,
    S_SSCAN  = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  // saturating signed add
  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      sat_add = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_add = s[VAL_W-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/hsra_mulsat.sv
// q16.16 multiplier with floor shift and saturation, two register stages
module hsra_mulsat import hsra_pkg::*; (
  input  logic                    clk,
  input  logic signed [VAL_W-1:0] a_val,
  input  logic signed [VAL_W-1:0] b_val,
  output logic signed [VAL_W-1:0] prod_sat
);

  logic signed [2*VAL_W-1:0] prod_r;
  logic signed [2*VAL_W-17:0] shr;
  logic signed [VAL_W-1:0]   sat_r;

  // arithmetic shift of the full product rounds toward minus infinity
  assign shr = prod_r[2*VAL_W-1:16];

  always_ff @(posedge clk) begin
    prod_r <= a_val * b_val;
    if (shr[2*VAL_W-17:VAL_W-1] == '0 || shr[2*VAL_W-17:VAL_W-1] == '1) begin
      sat_r <= shr[VAL_W-1:0];
    end else if (shr[2*VAL_W-17]) begin
      sat_r <= {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_r <= {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  assign prod_sat = sat_r;

endmodule

>>> hw/rtl/hsra_table.sv
// slot memory for keys and sums, slot used bits and the fill count
module hsra_table import hsra_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tbl_req_t                req,
  input  logic [KEY_W-1:0]        wr_key,
  input  logic signed [VAL_W-1:0] wr_sum,
  output logic [KEY_W-1:0]        rd_key,
  output logic signed [VAL_W-1:0] rd_sum,
  output logic [TABLE_DEPTH-1:0]  used,
  output logic [CNT_W-1:0]        used_count
);

  logic [KEY_W+VAL_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W+VAL_W-1:0] rd_data_r;
  logic [TABLE_DEPTH-1:0] used_r;
  logic [CNT_W-1:0]       used_count_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {wr_key, wr_sum};
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      used_count_r <= '0;
    end else if (req.clear_all) begin
      used_r       <= '0;
      used_count_r <= '0;
    end else if (req.set_used) begin
      used_r[req.wr_addr] <= 1'b1;
      used_count_r        <= used_count_r + CNT_W'(1);
    end
  end

  assign rd_key     = rd_data_r[KEY_W+VAL_W-1:VAL_W];
  assign rd_sum     = rd_data_r[VAL_W-1:0];
  assign used       = used_r;
  assign used_count = used_count_r;

endmodule

>>> hw/rtl/hash_sparse_row_accumulator.sv
// top level: sequencer for probing, accumulation and row flush
//
// channel  direction  fields
// in_      input      kind, column_key, a_value, b_value
// out_     output     key, value, entry_valid, overflow, last
// cfg_     input      we, index, wdata (write only)
//
// accumulate: multiply and saturate, then probe from the home slot; a free
//   slot takes the product, a used slot is read and compared and on a match
//   written back, else the next slot is probed (one memory read port)
// flush in slot order: empty slots are skipped, each used one is read out
//   and emitted; sorted flush: a full pass over the memory per emitted entry
// reset clears used bits, fill count and overflow flag at once, no sweep
// a stalled output holds the flush sequencer; accumulates go on while the
//   final result of a flush waits
module hash_sparse_row_accumulator import hsra_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [KEY_W-1:0]        in_column_key,
  input  logic signed [VAL_W-1:0] in_a_value,
  input  logic signed [VAL_W-1:0] in_b_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KEY_W-1:0]        out_key,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_entry_valid,
  output logic                    out_overflow,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  // configuration registers
  logic [2:0]       tsl_r;
  logic [CFG_W-1:0] mult_r;
  logic             sort_r;

  state_t state_r;

  // item being accumulated
  logic [KEY_W-1:0]        key_r;
  logic signed [VAL_W-1:0] a_r, b_r;
  logic [ADDR_W-1:0]       probe_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    ovf_r;

  // flush scan
  logic [CNT_W-1:0]        scan_r;
  logic                    pend_r;
  logic [ADDR_W-1:0]       pend_idx_r;
  logic                    found_r;
  logic [KEY_W-1:0]        best_key_r;
  logic signed [VAL_W-1:0] best_sum_r;
  logic [ADDR_W-1:0]       best_idx_r;
  logic                    have_last_r;
  logic [KEY_W-1:0]        last_key_r;
  logic [ADDR_W-1:0]       last_idx_r;
  logic [CNT_W-1:0]        emit_cnt_r;

  // output register
  logic                    out_valid_r;
  logic [KEY_W-1:0]        out_key_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_entry_r;
  logic                    out_ovf_r;
  logic                    out_last_r;

  // table interface
  tbl_req_t                req;
  logic [KEY_W-1:0]        wr_key, rd_key;
  logic signed [VAL_W-1:0] wr_sum, rd_sum, prod_sat;
  logic [TABLE_DEPTH-1:0]  used;
  logic [CNT_W-1:0]        used_count;

  logic [2:0]        lg;
  logic [CNT_W-1:0]  size;
  logic [ADDR_W-1:0] mask;
  logic [11:0]       hprod;
  logic              in_fire, out_free, emit_last, out_load;
  logic              cand_gt_last, cand_lt_best;

  hsra_mulsat u_mulsat (
    .clk      (clk),
    .a_val    (a_r),
    .b_val    (b_r),
    .prod_sat (prod_sat)
  );

  hsra_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .wr_key     (wr_key),
    .wr_sum     (wr_sum),
    .rd_key     (rd_key),
    .rd_sum     (rd_sum),
    .used       (used),
    .used_count (used_count)
  );

  // effective table size: zero acts as one, capped at the depth
  always_comb begin
    lg = tsl_r;
    if (lg == 3'd0) lg = 3'd1;
    if (lg == 3'd7) lg = 3'd6;
  end
  assign size  = CNT_W'(1) << lg;
  assign mask  = ADDR_W'(size - CNT_W'(1));
  // low slot bits depend only on the low bits of key and multiplier
  assign hprod = in_column_key[ADDR_W-1:0] * mult_r[ADDR_W-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_last = (emit_cnt_r + CNT_W'(1)) == used_count;
  // output register takes a new item this cycle
  assign out_load  = out_free && (state_r == S_EMIT || state_r == S_EMPTY);

  // order for the sorted scan is key first, then slot
  assign cand_gt_last = !have_last_r || (rd_key > last_key_r) ||
                        (rd_key == last_key_r && pend_idx_r > last_idx_r);
  assign cand_lt_best = !found_r || (rd_key < best_key_r);

  always_comb begin
    req    = '0;
    wr_key = key_r;
    wr_sum = prod_sat;
    unique case (state_r)
      S_PROBE: begin
        req.wr_addr = probe_r;
        req.rd_addr = probe_r;
        if (!used[probe_r]) begin
          req.wr_en    = 1'b1;
          req.set_used = 1'b1;
        end else begin
          req.rd_en = 1'b1;
        end
      end
      S_CMP: begin
        req.wr_addr = probe_r;
        wr_sum      = sat_add(rd_sum, prod_sat);
        req.wr_en   = (rd_key == key_r);
      end
      S_USCAN: begin
        req.rd_addr = scan_r[ADDR_W-1:0];
        req.rd_en   = used[scan_r[ADDR_W-1:0]];
      end
      S_SSCAN: begin
        req.rd_addr = scan_r[ADDR_W-1:0];
        req.rd_en   = !scan_r[ADDR_W];
      end
      S_EMIT: begin
        req.clear_all = out_free && emit_last;
      end
      S_EMPTY: begin
        req.clear_all = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsl_r       <= 3'd6;
      mult_r      <= CFG_W'(107);
      sort_r      <= 1'b0;
      state_r     <= S_IDLE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TABLE_SIZE_LOG2: tsl_r  <= cfg_wdata[2:0];
          REG_HASH_MULTIPLIER: mult_r <= cfg_wdata;
          REG_SORT_OUTPUT:     sort_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            key_r       <= in_column_key;
            a_r         <= in_a_value;
            b_r         <= in_b_value;
            probe_r     <= hprod[ADDR_W-1:0] & mask;
            cnt_r       <= '0;
            scan_r      <= '0;
            pend_r      <= 1'b0;
            found_r     <= 1'b0;
            have_last_r <= 1'b0;
            emit_cnt_r  <= '0;
            if (in_kind == KIND_ACCUM) begin
              state_r <= S_MUL;
            end else if (used_count == '0) begin
              state_r <= S_EMPTY;
            end else if (sort_r) begin
              state_r <= S_SSCAN;
            end else begin
              state_r <= S_USCAN;
            end
          end
        end
        S_MUL: state_r <= S_SAT;
        S_SAT: state_r <= S_PROBE;
        S_PROBE: begin
          // free slot: insert done, else compare the stored key
          state_r <= used[probe_r] ? S_CMP : S_IDLE;
        end
        S_CMP: begin
          if (rd_key == key_r) begin
            state_r <= S_IDLE;
          end else if (cnt_r == size - CNT_W'(1)) begin
            // every slot of this size visited: drop the product
            ovf_r   <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            probe_r <= (probe_r + ADDR_W'(1)) & mask;
            cnt_r   <= cnt_r + CNT_W'(1);
            state_r <= S_PROBE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_key_r   <= '0;
            out_value_r <= '0;
            out_entry_r <= 1'b0;
            out_ovf_r   <= ovf_r;
            out_last_r  <= 1'b1;
            ovf_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_USCAN: begin
          if (used[scan_r[ADDR_W-1:0]]) begin
            best_idx_r <= scan_r[ADDR_W-1:0];
            state_r    <= S_UFETCH;
          end else begin
            scan_r <= scan_r + CNT_W'(1);
          end
        end
        S_UFETCH: begin
          best_key_r <= rd_key;
          best_sum_r <= rd_sum;
          state_r    <= S_EMIT;
        end
        S_SSCAN: begin
          // a slot read is issued, its data compared in the next cycle
          pend_r     <= !scan_r[ADDR_W] && used[scan_r[ADDR_W-1:0]];
          pend_idx_r <= scan_r[ADDR_W-1:0];
          if (!scan_r[ADDR_W]) scan_r <= scan_r + CNT_W'(1);
          if (pend_r && cand_gt_last && cand_lt_best) begin
            found_r    <= 1'b1;
            best_key_r <= rd_key;
            best_sum_r <= rd_sum;
            best_idx_r <= pend_idx_r;
          end
          if (scan_r[ADDR_W] && !pend_r) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_key_r   <= best_key_r;
            out_value_r <= best_sum_r;
            out_entry_r <= 1'b1;
            out_ovf_r   <= ovf_r;
            out_last_r  <= emit_last;
            emit_cnt_r  <= emit_cnt_r + CNT_W'(1);
            have_last_r <= 1'b1;
            last_key_r  <= best_key_r;
            last_idx_r  <= best_idx_r;
            found_r     <= 1'b0;
            pend_r      <= 1'b0;
            if (emit_last) begin
              ovf_r   <= 1'b0;
              state_r <= S_IDLE;
            end else if (sort_r) begin
              scan_r  <= '0;
              state_r <= S_SSCAN;
            end else begin
              scan_r  <= CNT_W'(best_idx_r) + CNT_W'(1);
              state_r <= S_USCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key         = out_key_r;
  assign out_value       = out_value_r;
  assign out_entry_valid = out_entry_r;
  assign out_overflow    = out_ovf_r;
  assign out_last        = out_last_r;

  // fill count agrees with the used bits whenever the sequencer is idle
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (32'(used_count) == 32'($countones(used))))
    else $error("fill count differs from used bits");

  // the fill count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond depth");

  // a final flush result leaves an empty table behind
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (req.clear_all) |=> (used == '0 && !ovf_r))
    else $error("table not cleared after flush");

endmodule

>>> sim/tb_hash_sparse_row_accumulator.sv
// testbench of the hash row accumulator: directed table, then random rows under several settings
module tb_hash_sparse_row_accumulator;
  import hsra_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
  localparam int DRAIN_CYCLES   = 200;    // covers the longest probe walk
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // one emitted entry as seen on the out_ channel
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             entry_valid;
    logic             overflow;
    logic             last;
  } row_entry_t;

  // one row of the directed table; typed rows carry their flush result
  typedef struct {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    bit               typed;
    row_entry_t       want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_kind;
  logic [KEY_W-1:0]        in_column_key;
  logic signed [VAL_W-1:0] in_a_value;
  logic signed [VAL_W-1:0] in_b_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [KEY_W-1:0]        out_key;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_entry_valid;
  logic                    out_overflow;
  logic                    out_last;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;

  hash_sparse_row_accumulator dut (.*);

  // accumulator shadow: table, fill flag and register copies
  logic [KEY_W-1:0] acc_key[TABLE_DEPTH];
  logic [VAL_W-1:0] acc_sum[TABLE_DEPTH];
  bit               acc_used[TABLE_DEPTH];
  bit               acc_dropped;
  int unsigned      size_log2_reg;
  int unsigned      mult_reg;
  bit               sorted_reg;

  row_entry_t  entries_due[$];   // results still owed by the block, oldest first
  row_entry_t  flush_list[$];    // scratch: what the last flush emits
  stim_row_t   dir_tab[20];

  int  errors;
  int  items_sent;
  int  results_seen;
  int  flushes_sent;
  int  overflow_rows;
  int  idle_cycles;
  bit  no_gaps;        // stretch where neither side idles
  bit  hold_request;   // ask the receiver for one long hold-off
  bit  hold_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic logic [VAL_W-1:0] clamp32(input longint v);
    if (v > longint'(32'sh7fffffff)) return VAL_MAX;
    if (v < -longint'(64'sh80000000)) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  // q16.16 product, floor rounding, saturated
  function automatic logic [VAL_W-1:0] q16_product(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 16);
  endfunction

  // linear probe from the home slot; a full table drops the product
  function automatic void add_product(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] prod);
    int unsigned lg;
    int unsigned size;
    longint unsigned h;
    lg = size_log2_reg;
    if (lg < 1) lg = 1;
    if (lg > 6) lg = 6;
    size = 1 << lg;
    h = (longint'(key) * longint'(mult_reg)) & (size - 1);
    for (int n = 0; n < size; n++) begin
      if (acc_used[h] && acc_key[h] == key) begin
        acc_sum[h] = clamp32(longint'($signed(acc_sum[h])) + longint'($signed(prod)));
        return;
      end
      if (!acc_used[h]) begin
        acc_used[h] = 1'b1;
        acc_key[h]  = key;
        acc_sum[h]  = prod;
        return;
      end
      h = (h + 1) & (size - 1);
    end
    acc_dropped = 1'b1;
  endfunction

  // scan every slot, optionally stable-sort by key, then clear the row
  function automatic void flush_row();
    row_entry_t e;
    int j;
    flush_list.delete();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (acc_used[i]) begin
        e = '{acc_key[i], acc_sum[i], 1'b1, acc_dropped, 1'b0};
        if (sorted_reg) begin
          j = flush_list.size();
          while (j > 0 && flush_list[j-1].key > e.key) j--;
          flush_list.insert(j, e);
        end else begin
          flush_list.insert(flush_list.size(), e);
        end
      end
    end
    if (flush_list.size() == 0) begin
      e = '{'0, '0, 1'b0, acc_dropped, 1'b1};
      flush_list.insert(0, e);
    end else begin
      flush_list[flush_list.size()-1].last = 1'b1;
    end
    if (acc_dropped) overflow_rows++;
    foreach (acc_used[i]) acc_used[i] = 1'b0;
    acc_dropped = 1'b0;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TABLE_SIZE_LOG2: size_log2_reg = value & 7;
      REG_HASH_MULTIPLIER: mult_reg = value & 16'hffff;
      REG_SORT_OUTPUT:     sorted_reg = value & 1;
      default: ;
    endcase
  endtask

  // offer one item, wait for acceptance, then update the shadow
  task automatic send_item(input stim_row_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= r.kind;
    in_column_key <= r.key;
    in_a_value    <= r.a;
    in_b_value    <= r.b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (r.kind == KIND_ACCUM) begin
      add_product(r.key, q16_product(r.a, r.b));
    end else begin
      flushes_sent++;
      flush_row();
      if (r.typed) entries_due.insert(entries_due.size(), r.want);
      else foreach (flush_list[i]) entries_due.insert(entries_due.size(), flush_list[i]);
    end
  endtask

  // pause the sender until the block has delivered everything and gone quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h3ffff) - 32'h20000;  // within +-2.0
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request, field by field check
  initial begin
    row_entry_t want;
    int stall;
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (hold_request && !hold_done) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (entries_due.size() == 0) begin
        report("result with nothing due", {out_key, out_value}, '0);
      end else begin
        want = entries_due.pop_front();
        if (out_key !== want.key) report("key", out_key, want.key);
        if (out_value !== want.value) report("value", out_value, want.value);
        if (out_entry_valid !== want.entry_valid)
          report("entry_valid", out_entry_valid, want.entry_valid);
        if (out_overflow !== want.overflow) report("overflow", out_overflow, want.overflow);
        if (out_last !== want.last) report("last", out_last, want.last);
      end
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", entries_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t r;
    logic [KEY_W-1:0] pool[16];
    int unsigned phase_log2[8];
    int unsigned phase_sort[8];
    int unsigned size;
    int pool_n;
    int row_len;
    int phase_items;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_ACCUM;
    in_column_key = '0;
    in_a_value    = '0;
    in_b_value    = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_TABLE_SIZE_LOG2;
    cfg_wdata     = '0;
    errors = 0; items_sent = 0; results_seen = 0; flushes_sent = 0;
    overflow_rows = 0; idle_cycles = 0; no_gaps = 1'b0; hold_request = 1'b0;
    size_log2_reg = 6; mult_reg = 107; sorted_reg = 1'b0; acc_dropped = 1'b0;
    foreach (acc_used[i]) acc_used[i] = 1'b0;

    // directed rows under the reset settings: 64 slots, multiplier 107, slot order
    dir_tab[0]  = '{KIND_FLUSH, '0, '0, '0, 1, '{'0, '0, 1'b0, 1'b0, 1'b1}};  // empty row
    dir_tab[1]  = '{KIND_ACCUM, KEY_MAX, VAL_MAX, VAL_MAX, 0, '{default: '0}};
    dir_tab[2]  = '{KIND_FLUSH, '0, '0, '0, 1, '{KEY_MAX, VAL_MAX, 1'b1, 1'b0, 1'b1}};
    dir_tab[3]  = '{KIND_ACCUM, '0, VAL_MIN, VAL_MAX, 0, '{default: '0}};
    dir_tab[4]  = '{KIND_FLUSH, '0, '0, '0, 1, '{'0, VAL_MIN, 1'b1, 1'b0, 1'b1}};
    dir_tab[5]  = '{KIND_ACCUM, 31'd9, VAL_MIN, VAL_MIN, 0, '{default: '0}};
    dir_tab[6]  = '{KIND_ACCUM, 31'd9, 32'h10000, 32'h10000, 0, '{default: '0}};  // sum saturates
    dir_tab[7]  = '{KIND_FLUSH, '0, '0, '0, 1, '{31'd9, VAL_MAX, 1'b1, 1'b0, 1'b1}};
    dir_tab[8]  = '{KIND_ACCUM, 31'd3, '0, 32'd123, 0, '{default: '0}};  // zero product kept
    dir_tab[9]  = '{KIND_FLUSH, '0, '0, '0, 1, '{31'd3, '0, 1'b1, 1'b0, 1'b1}};
    dir_tab[10] = '{KIND_ACCUM, 31'd4, 32'hffffffff, 32'd1, 0, '{default: '0}};  // floors to -1
    dir_tab[11] = '{KIND_FLUSH, '0, '0, '0, 1, '{31'd4, 32'hffffffff, 1'b1, 1'b0, 1'b1}};
    dir_tab[12] = '{KIND_ACCUM, 31'd4, 32'd1, 32'd1, 0, '{default: '0}};  // floors to 0
    // flush fields are don't-care
    dir_tab[13] = '{KIND_FLUSH, KEY_MAX, 32'hffffffff, 32'hffffffff, 1,
                    '{31'd4, '0, 1'b1, 1'b0, 1'b1}};
    // keys 1, 65, 129 share a home slot: probe chain
    dir_tab[14] = '{KIND_ACCUM, 31'd1, 32'h20000, 32'h8000, 0, '{default: '0}};
    dir_tab[15] = '{KIND_ACCUM, 31'd65, 32'h18000, 32'hfffe0000, 0, '{default: '0}};
    dir_tab[16] = '{KIND_ACCUM, 31'd129, 32'h7fff0000, 32'h30000, 0, '{default: '0}};
    dir_tab[17] = '{KIND_ACCUM, 31'd1, 32'h10000, 32'h10000, 0, '{default: '0}};
    dir_tab[18] = '{KIND_ACCUM, 31'd129, 32'h80000000, 32'h10000, 0, '{default: '0}};
    dir_tab[19] = '{KIND_FLUSH, '0, '0, '0, 0, '{default: '0}};

    // settings per random phase: sizes 2..64, out-of-range codes 0 and 7
    phase_log2 = '{1, 6, 0, 7, 3, 2, 4, 5};
    phase_sort = '{0, 1, 1, 0, 1, 0, 1, 0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i]);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_TABLE_SIZE_LOG2, phase_log2[ph]);
      cfg_write(REG_HASH_MULTIPLIER, ph == 0 ? 1 : ph == 1 ? 16'hffff : $urandom_range(1, 16'hffff));
      cfg_write(REG_SORT_OUTPUT, phase_sort[ph]);
      hold_request = (ph == 1);
      no_gaps      = (ph == 3);
      size = 1 << ((phase_log2[ph] < 1) ? 1 : (phase_log2[ph] > 6) ? 6 : phase_log2[ph]);
      phase_items = 0;
      while (phase_items < 55) begin
        pool_n = (size + 2 > 16) ? 16 : size + 2;
        foreach (pool[k])
          pool[k] = ($urandom_range(0, 3) == 0) ? ($urandom & KEY_MAX) : $urandom_range(0, 200);
        // small tables sometimes get overfilled on purpose
        if (size <= 8 && $urandom_range(0, 3) == 0)
          row_len = size + 2 + $urandom_range(0, 3);
        else
          row_len = $urandom_range(0, (size < 10) ? size : 10);
        for (int n = 0; n < row_len; n++) begin
          r = '{KIND_ACCUM, pool[$urandom_range(0, pool_n - 1)], pick_value(), pick_value(),
                0, '{default: '0}};
          if ($urandom_range(0, 11) == 0) r.key = $urandom & KEY_MAX;  // stray key
          send_item(r);
          phase_items++;
        end
        r = '{KIND_FLUSH, $urandom & KEY_MAX, $urandom, $urandom, 0, '{default: '0}};
        send_item(r);
        phase_items++;
      end
      wait_drained();
    end

    $display("sent %0d items (%0d flushes, %0d rows with drops), checked %0d results",
             items_sent, flushes_sent, overflow_rows, results_seen);
    $display("covered table sizes 2 to 64, size codes 0 and 7, slot and key order");
    if (errors == 0 && entries_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (entries_due.size() != 0) $display("%0d results never arrived", entries_due.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
